FILE: hw/rtl/output_restricted_deque_defines.svh
// Assertion macros shared by the output-restricted deque RTL.
// Depends on nothing; included by output_restricted_deque.
`ifndef OUTPUT_RESTRICTED_DEQUE_DEFINES_SVH
`define OUTPUT_RESTRICTED_DEQUE_DEFINES_SVH

// Property checked at each rising clock edge, off while reset is high.
`define ORD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at each rising clock edge, reset included.
`define ORD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/ord_pkg.sv
// Shared types and constants of the output-restricted deque.
// Depends on nothing; used by ord_cell and output_restricted_deque.
package ord_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int OPCODE_W = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int CAP_W    = 5;

   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 8;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 8;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Operation codes.
   localparam logic [OPCODE_W-1:0] OP_INS_REAR  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_INS_FRONT = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_REM_REAR  = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Per-cell move controls for one cycle.
   typedef struct packed {
      logic shift_up;     // take the word of the neighbor nearer the rear
      logic shift_down;   // take the word of the neighbor nearer the front
      logic load_front;   // take the incoming word as the new front entry
   } ord_cell_ctl_type;

endpackage

FILE: hw/rtl/ord_cell.sv
// One storage cell of the deque row: holds one entry and passes it along.
// Depends on ord_pkg.
module ord_cell (
   input  logic                           clock,
   input  ord_pkg::ord_cell_ctl_type      ctl,
   input  logic [ord_pkg::VALUE_W-1:0]    lower_data,
   input  logic [ord_pkg::VALUE_W-1:0]    upper_data,
   input  logic [ord_pkg::VALUE_W-1:0]    word,
   output logic [ord_pkg::VALUE_W-1:0]    data
);
   import ord_pkg::*;

   logic [VALUE_W-1:0] data_ff;
   logic [VALUE_W-1:0] data_in;

   // Pick the source of this cell's next entry.
   always_comb begin
      data_in = data_ff;
      if (ctl.load_front) begin
         data_in = word;
      end else if (ctl.shift_up) begin
         data_in = lower_data;
      end else if (ctl.shift_down) begin
         data_in = upper_data;
      end
   end

   // Entry storage needs no reset; it is only read after being written.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

FILE: hw/rtl/output_restricted_deque.sv
// Top level of the output-restricted deque built as a row of shifting cells.
// Depends on ord_pkg, ord_cell and output_restricted_deque_defines.svh.
`include "output_restricted_deque_defines.svh"

// The deque takes one operation beat per clock cycle unless stalled; each beat
// changes the entry count and the row of cells at most once, with the rear
// entry always in cell 0, so the response for a beat is ready in the cycle
// after it is taken. The response sits in one output register, and a new
// request beat is taken in the same cycle that the waiting response is taken.
// A write to the capacity register empties the deque at once; no clearing pass
// is needed after reset. Capacity values of 0 act as 1 and values above DEPTH
// act as DEPTH. Opcode 3 does nothing and reports the current count and flags.
module output_restricted_deque #(
   parameter int DEPTH = ord_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Capacity register write port.
   input  logic                              csr_wr_en,
   input  logic [ord_pkg::CAP_W-1:0]         csr_wr_data,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ord_pkg::REQ_TDATA_W-1:0]   req_tdata,   // [31:0] value
   input  logic [ord_pkg::REQ_TUSER_W-1:0]   req_tuser,   // [1:0] opcode, [7:2] zero
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] removed_value, [36:32] entry_count, [37] is_empty, [38] is_full,
   // [39] zero
   output logic [ord_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [ord_pkg::RSP_TUSER_W-1:0]   rsp_tuser    // [1:0] status, [7:2] zero
);
   import ord_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int PAD_W = RSP_TDATA_W - VALUE_W - COUNT_W - 2;

   logic [CAP_W-1:0]       cap_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;
   logic [STATUS_W-1:0]    rsp_status_ff;

   logic [CW-1:0]          eff_cap;
   logic [CW-1:0]          cap_ext;
   logic [OPCODE_W-1:0]    opcode;
   logic [VALUE_W-1:0]     word;
   logic                   req_fire;
   logic                   is_insert;
   logic                   do_ins;
   logic                   do_rem;
   logic [STATUS_W-1:0]    status_c;
   logic [VALUE_W-1:0]     removed_c;
   logic [CNT_W-1:0]       count_next;

   ord_cell_ctl_type       cell_ctl  [DEPTH];
   logic [VALUE_W-1:0]     cell_data [DEPTH];

   assign opcode   = req_tuser[OPCODE_W-1:0];
   assign word     = req_tdata[VALUE_W-1:0];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire = req_tvalid && req_tready;

   // Clamp the capacity register to 1..DEPTH.
   always_comb begin
      cap_ext = CW'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = CW'(1);
      end else if (cap_ext > CW'(DEPTH)) begin
         eff_cap = CW'(DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end

   // Decide the outcome of the request on the channel.
   always_comb begin
      is_insert  = (opcode == OP_INS_REAR) || (opcode == OP_INS_FRONT);
      do_ins     = 1'b0;
      do_rem     = 1'b0;
      status_c   = ST_DONE;
      removed_c  = '0;
      count_next = count_ff;
      if (is_insert) begin
         if (CW'(count_ff) >= eff_cap) begin
            status_c = ST_FULL;
         end else begin
            do_ins     = 1'b1;
            count_next = count_ff + CNT_W'(1);
         end
      end else if (opcode == OP_REM_REAR) begin
         if (count_ff == '0) begin
            status_c = ST_EMPTY;
         end else begin
            do_rem     = 1'b1;
            removed_c  = cell_data[0];
            count_next = count_ff - CNT_W'(1);
         end
      end
   end

   // Row controls: rear inserts push the row up, removals pull it down,
   // front inserts land in the first free cell.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ctl[i].shift_up   = req_fire && do_ins && (opcode == OP_INS_REAR);
         cell_ctl[i].shift_down = req_fire && do_rem;
         cell_ctl[i].load_front = req_fire && do_ins && (opcode == OP_INS_FRONT) &&
                                  (count_ff == CNT_W'(i));
      end
   end

   // The row of cells; cell 0 holds the rear entry.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [VALUE_W-1:0] lower_w;
      logic [VALUE_W-1:0] upper_w;
      if (g == 0) begin : g_rear
         assign lower_w = word;
      end else begin : g_mid_lo
         assign lower_w = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_front
         assign upper_w = '0;
      end else begin : g_mid_hi
         assign upper_w = cell_data[g+1];
      end
      ord_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[g]),
         .lower_data (lower_w),
         .upper_data (upper_w),
         .word       (word),
         .data       (cell_data[g])
      );
   end

   // Next count: a capacity write empties the deque.
   always_comb begin
      count_in = count_ff;
      if (csr_wr_en) begin
         count_in = '0;
      end else if (req_fire) begin
         count_in = count_next;
      end
   end

   // Response beat contents.
   always_comb begin
      rsp_data_in = {{PAD_W{1'b0}},
                     (CW'(count_next) == eff_cap),
                     (count_next == '0),
                     COUNT_W'(count_next),
                     removed_c};
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= status_c;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {{(RSP_TUSER_W - STATUS_W){1'b0}}, rsp_status_ff};

   // Checks on the count and the response register.
   `ORD_ASSERT(a_count_in_cap, clock, reset, CW'(count_ff) <= eff_cap, "count above capacity")
   `ORD_ASSERT(a_reject_holds, clock, reset, req_fire && !csr_wr_en && status_c != ST_DONE |=> $stable(count_ff), "rejected beat changed the count")
   `ORD_ASSERT(a_remove_dec, clock, reset, req_fire && !csr_wr_en && do_rem |=> count_ff == $past(count_ff) - CNT_W'(1), "removal did not lower the count")
   `ORD_ASSERT(a_fire_rsp, clock, reset, req_fire |=> rsp_valid_ff, "accepted beat gave no response")
   `ORD_ASSERT(a_empty_flag, clock, reset, rsp_valid_ff |-> rsp_data_ff[VALUE_W+COUNT_W] == (rsp_data_ff[VALUE_W+COUNT_W-1:VALUE_W] == '0), "empty flag disagrees with count")

endmodule
